// File: design/bafe_pkg.sv
// Shared widths, register indexes and reset values for the box average filter.
package bafe_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int RADIUS_W   = 3;
    localparam int FRAC_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int DIVIDEND_W = 16;

    typedef logic [DIVIDEND_W-1:0] dividend_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    localparam cfg_idx_t REG_RADIUS    = 2'd0;
    localparam cfg_idx_t REG_NORM_MODE = 2'd1;
    localparam cfg_idx_t REG_FRAC_BITS = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd1;
    localparam logic [FRAC_W-1:0]   FRAC_RESET   = 4'd8;

    localparam logic NORM_DIVIDE = 1'b0;
    localparam logic NORM_RECIP  = 1'b1;

    localparam logic [SAMPLE_W-1:0] AVG_MAX = '1;

endpackage

// File: design/bafe_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module bafe_div #(
    parameter int DIVISOR_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  bafe_pkg::dividend_t dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                done,
    output bafe_pkg::dividend_t quotient
);
    import bafe_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    dividend_t            quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [DIVISOR_W:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so the trial fits one extra bit
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/box_average_filter_edge_replicate.sv
// Each output sums the 2r+1 window taps serially and runs the serial divider, then goes straight
// to the output register (mode 0) or through multiply and scale first (mode 1); r is the clamped radius.
// Throughput: one sample per item; the item holds the block for all outputs it causes
// (up to r+1 on the last sample of a line), set by the serial tap sum and the shared divider.
// Input is not ready while an item is in work or a result waits on the output.
// Reset (rst_n, asynchronous, low) empties the line and restores radius 1, mode 0, q 8.
module box_average_filter_edge_replicate #(
    parameter int MAX_RADIUS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bafe_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [7:0] sample
    input  logic                          s_axis_tlast,   // line_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bafe_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [7:0] average
    output logic                          m_axis_tlast,   // final_res
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  bafe_pkg::cfg_idx_t            cfg_index,
    input  logic [bafe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bafe_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int DIVISOR_W = $clog2(2 * MAX_RADIUS + 2);
    localparam int POS_W     = DIVISOR_W + 1;
    localparam int SUM_W     = $clog2(WIN_DEPTH * 255 + 1);
    localparam int PROD_W    = DIVIDEND_W + SUM_W;
    localparam int RCMP_W    = (RAD_W > RADIUS_W) ? RAD_W : RADIUS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic                norm_reg, norm_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;

    logic [SAMPLE_W-1:0] window_reg [WIN_DEPTH];
    logic [SAMPLE_W-1:0] window_next [WIN_DEPTH];
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic [RAD_W-1:0]     lag_reg, lag_next;
    logic [DIVISOR_W-1:0] tap_reg, tap_next;
    logic                 last_reg, last_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [SAMPLE_W-1:0]  avg_reg, avg_next;
    logic                 final_reg, final_next;

    logic [RCMP_W-1:0]       radius_cmp;
    logic [RAD_W-1:0]        r_eff;
    logic [SEEN_W-1:0]       seen_inc;
    logic [POS_W-1:0]        seen_m1;
    logic signed [POS_W-1:0] tap_pos;
    logic signed [POS_W-1:0] top_pos;
    logic [IDX_W-1:0]        tap_idx;
    logic [SAMPLE_W-1:0]     tap_val;
    logic [DIVISOR_W-1:0]    divisor;
    dividend_t               dividend;
    dividend_t               quotient;
    logic                    div_start;
    logic                    div_done;
    logic [PROD_W-1:0]       half;
    logic [PROD_W-1:0]       shifted;

    always_comb
    begin
        radius_cmp = RCMP_W'(radius_reg);
        r_eff      = (radius_cmp > RCMP_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                        : RAD_W'(radius_cmp);
        seen_inc   = (seen_reg < SEEN_W'(WIN_DEPTH)) ? seen_reg + 1'b1 : seen_reg;
        seen_m1    = POS_W'(seen_inc) - 1'b1;

        // replicate edges: clamp the tap offset into the samples held so far
        tap_pos = POS_W'(lag_reg) + POS_W'(r_eff) - POS_W'(tap_reg);
        top_pos = POS_W'(seen_reg) - 1'b1;
        if (tap_pos < 0)
            tap_idx = '0;
        else if (tap_pos > top_pos)
            tap_idx = IDX_W'(top_pos);
        else
            tap_idx = IDX_W'(tap_pos);
        tap_val = window_reg[tap_idx];

        divisor   = DIVISOR_W'({r_eff, 1'b1});
        dividend  = (norm_reg == NORM_DIVIDE) ? DIVIDEND_W'(sum_reg) + DIVIDEND_W'(r_eff)
                                              : DIVIDEND_W'(1) << frac_reg;
        div_start = (state_reg == ST_DIV_START);
        half      = (PROD_W'(1) << frac_reg) >> 1;
        shifted   = prod_reg >> frac_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        radius_next = radius_reg;
        norm_next   = norm_reg;
        frac_next   = frac_reg;
        window_next = window_reg;
        seen_next   = seen_reg;
        lag_next    = lag_reg;
        tap_next    = tap_reg;
        last_next   = last_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        avg_next    = avg_reg;
        final_next  = final_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RADIUS:    radius_next = cfg_data[RADIUS_W-1:0];
                REG_NORM_MODE: norm_next   = cfg_data[0];
                REG_FRAC_BITS: frac_next   = cfg_data[FRAC_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    window_next[0] = s_axis_tdata;
                    for (int i = 1; i < WIN_DEPTH; i++)
                        window_next[i] = window_reg[i-1];
                    seen_next = seen_inc;
                    last_next = s_axis_tlast;
                    tap_next  = '0;
                    sum_next  = '0;
                    if (s_axis_tlast)
                    begin
                        // flush: start at the oldest position still owed
                        lag_next   = (POS_W'(r_eff) < seen_m1) ? r_eff : RAD_W'(seen_m1);
                        state_next = ST_SUM;
                    end
                    else if (POS_W'(seen_inc) > POS_W'(r_eff))
                    begin
                        lag_next   = r_eff;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                sum_next = sum_reg + SUM_W'(tap_val);
                if (tap_reg == DIVISOR_W'({r_eff, 1'b0}))
                    state_next = ST_DIV_START;
                else
                    tap_next = tap_reg + 1'b1;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (norm_reg == NORM_DIVIDE)
                    begin
                        avg_next   = (quotient > DIVIDEND_W'(AVG_MAX)) ? AVG_MAX
                                                                      : quotient[SAMPLE_W-1:0];
                        final_next = last_reg && (lag_reg == '0);
                        state_next = ST_OUT;
                    end
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // quotient holds the reciprocal floor(2^q / (2r+1))
                prod_next  = quotient * sum_reg + half;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                avg_next   = (shifted > PROD_W'(AVG_MAX)) ? AVG_MAX : shifted[SAMPLE_W-1:0];
                final_next = last_reg && (lag_reg == '0);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (last_reg && (lag_reg != '0))
                    begin
                        lag_next   = lag_reg - 1'b1;
                        tap_next   = '0;
                        sum_next   = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        if (last_reg)
                            seen_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            radius_reg <= RADIUS_RESET;
            norm_reg   <= NORM_DIVIDE;
            frac_reg   <= FRAC_RESET;
            seen_reg   <= '0;
            lag_reg    <= '0;
            tap_reg    <= '0;
            last_reg   <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            radius_reg <= radius_next;
            norm_reg   <= norm_next;
            frac_reg   <= frac_next;
            seen_reg   <= seen_next;
            lag_reg    <= lag_next;
            tap_reg    <= tap_next;
            last_reg   <= last_next;
            final_reg  <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        avg_reg    <= avg_next;
    end

    bafe_div #(
        .DIVISOR_W (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = avg_reg;
    assign m_axis_tlast  = final_reg;
    assign cfg_ready     = 1'b1;

endmodule

// File: design/bafe_checker.sv
// Port-level checks for the box average filter, bound to the top level.
module bafe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // input side is closed while a result is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // a result needs compute cycles after the sample that causes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result offered right after input transfer");

    // each result is computed afresh: no back-to-back output transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("output valid right after output transfer");

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind box_average_filter_edge_replicate bafe_checker u_bafe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
